FILE: sv/r2dc_pkg.sv
// Shared types and constants of the raster 2-D convolution block.
package r2dc_pkg;

    localparam int VALUE_W   = 8;
    localparam int POS_W     = 11;
    localparam int CFG_W     = 12;
    localparam int RAD_W     = 2;
    localparam int OP_W      = 2;
    localparam int COEF_W    = 16;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int KSLOTS    = 49;
    localparam int PEND_W    = 24;
    // unsigned sample times signed coefficient
    localparam int PROD_W    = VALUE_W + 1 + COEF_W;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;
    localparam logic [RAD_W-1:0] RADIUS_RST = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_PIXEL = 2'd0,
        OP_COEF  = 2'd1,
        OP_FLUSH = 2'd2
    } t_op;

    typedef struct packed {
        logic shift;
        logic adv;
    } t_cell_ctl;

    typedef struct packed {
        logic             emit;
        logic             border;
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_meta;

endpackage

FILE: sv/r2dc_line_store.sv
// Row buffers: one byte-wide memory per row slot, all read at the same column.
module r2dc_line_store #(
    parameter int DEPTH = 2048,
    parameter int SLOTS = 7
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [$clog2(SLOTS)-1:0]                      i_wslot,
    input  logic [$clog2(DEPTH)-1:0]                      i_addr,
    input  logic [r2dc_pkg::VALUE_W-1:0]                  i_wdata,
    input  logic                                          i_re,
    output logic [SLOTS-1:0][r2dc_pkg::VALUE_W-1:0]       o_rdata
);

    for (genvar s = 0; s < SLOTS; s++) begin : g_slot
        logic [r2dc_pkg::VALUE_W-1:0] mem [DEPTH];
        logic [r2dc_pkg::VALUE_W-1:0] r_rdata;

        // write the new sample into its row slot, read the column of every slot
        always_ff @(posedge i_clk) begin
            if (i_we && (i_wslot == $clog2(SLOTS)'(s))) begin
                mem[i_addr] <= i_wdata;
            end
            if (i_re) begin
                r_rdata <= mem[i_addr];
            end
        end

        assign o_rdata[s] = r_rdata;
    end

endmodule

FILE: sv/r2dc_cell.sv
// One window column: holds its samples, passes them on, and forms its dot product.
module r2dc_cell #(
    parameter int ROWS   = 7,
    parameter int CSUM_W = 28
) (
    input  logic                                       i_clk,
    input  r2dc_pkg::t_cell_ctl                        i_ctl,
    input  logic [ROWS-1:0][r2dc_pkg::VALUE_W-1:0]     i_col,
    input  logic [ROWS-1:0][r2dc_pkg::COEF_W-1:0]      i_coef,
    output logic [ROWS-1:0][r2dc_pkg::VALUE_W-1:0]     o_col,
    output logic signed [CSUM_W-1:0]                   o_sum
);

    logic [ROWS-1:0][r2dc_pkg::VALUE_W-1:0] r_col;
    logic signed [r2dc_pkg::PROD_W-1:0]     r_prod [ROWS];
    logic signed [CSUM_W-1:0]               r_sum;
    logic signed [CSUM_W-1:0]               n_sum;

    // shift the column in from the neighbor on each pixel
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_col <= i_col;
        end
    end

    // register products, then the column sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            for (int a = 0; a < ROWS; a++) begin
                r_prod[a] <= $signed({1'b0, r_col[a]}) * $signed(i_coef[a]);
            end
            r_sum <= n_sum;
        end
    end

    always_comb begin
        n_sum = '0;
        for (int a = 0; a < ROWS; a++) begin
            n_sum = n_sum + CSUM_W'(r_prod[a]);
        end
    end

    assign o_col = r_col;
    assign o_sum = r_sum;

endmodule

FILE: sv/raster_2d_convolution.sv
// Top level of the streaming 2-D convolution over raster gray samples.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser: operation; tdata: sample,
//                                                      coef_index, coef_value
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: value, row, column; tlast: last
//  cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One request is taken per clock while the output is not held. A result passes the row
// buffer read, then window shift, products, column sums, window sum and the output
// register after the request that releases it. The chain of 2R+1 column cells fixes the
// window. Reset clears counters, coefficients and registers at once; no clearing pass.
// A held output stalls the whole pipeline, and s_axis_tready drops with it.
module raster_2d_convolution #(
    parameter int MAX_WIDTH      = 2048,
    parameter int MAX_HEIGHT     = 2048,
    parameter int MAX_RADIUS     = 3,
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] sample, [13:8] coef_index, [29:14] coef_value, [31:30] zero
    input  logic [31:0]                         s_axis_tdata,
    // [1:0] operation
    input  logic [r2dc_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] value, [18:8] row, [29:19] column, [31:30] zero
    output logic [31:0]                         m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [r2dc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [r2dc_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int RMAX   = (MAX_RADIUS < 3) ? MAX_RADIUS : 3;
    localparam int CN     = 2 * RMAX + 1;
    localparam int NSLOT  = 2 * MAX_RADIUS + 1;
    localparam int NCOEF  = (NSLOT * NSLOT < r2dc_pkg::KSLOTS) ? NSLOT * NSLOT
                                                               : r2dc_pkg::KSLOTS;
    localparam int SW     = $clog2(NSLOT);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int TW     = WW + r2dc_pkg::RAD_W;
    localparam int CSUM_W = r2dc_pkg::PROD_W + $clog2(CN);
    localparam int TOT_W  = CSUM_W + $clog2(CN);
    localparam int VW     = r2dc_pkg::VALUE_W;
    localparam int PW     = r2dc_pkg::POS_W;

    // configuration
    logic [r2dc_pkg::CFG_W-1:0] r_width, r_height;
    logic [r2dc_pkg::RAD_W-1:0] r_radius;

    // input and output raster position
    logic [CW-1:0]                r_in_col, n_in_col, r_out_col, n_out_col;
    logic [RW-1:0]                r_in_row, n_in_row, r_out_row, n_out_row;
    logic [SW-1:0]                r_in_slot, n_in_slot;
    logic [r2dc_pkg::PEND_W-1:0]  r_pend, n_pend;

    logic signed [r2dc_pkg::COEF_W-1:0] r_coef [r2dc_pkg::KSLOTS];

    // coefficient load, registered and applied at the next pipeline advance to line up with the products
    logic                               r_cw_en;
    logic [r2dc_pkg::IDX_W-1:0]         r_cw_idx;
    logic signed [r2dc_pkg::COEF_W-1:0] r_cw_val;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [r2dc_pkg::RAD_W-1:0] eff_r;
    logic [TW-1:0] thr;

    logic adv, acc, is_pix, is_coef, is_flush, emit;
    logic [CW-1:0] cur_col, ocol;
    logic [RW-1:0] cur_row, orow;
    logic [SW-1:0] cur_slot;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;
    logic [r2dc_pkg::PEND_W-1:0] pend_inc;
    logic out_ok, border, last;
    r2dc_pkg::t_meta a_meta;

    // pipeline stages
    logic                r_b_pix;
    logic [VW-1:0]       r_b_sample;
    logic [SW-1:0]       r_b_slot;
    r2dc_pkg::t_meta     r_b_meta, r_c_meta, r_d_meta, r_e_meta, r_f_meta;
    logic signed [TOT_W-1:0] r_total, n_total;
    logic                r_o_valid;
    logic [VW-1:0]       r_o_value;
    logic [PW-1:0]       r_o_row, r_o_col;
    logic                r_o_last;
    logic [VW-1:0]       sat_value;

    logic [NSLOT-1:0][VW-1:0] rd;
    logic [CN-1:0][VW-1:0]    chain [CN];
    logic [CN-1:0][VW-1:0]    col_vec;
    logic [CN-1:0][r2dc_pkg::COEF_W-1:0] cell_coef [CN];
    logic signed [CSUM_W-1:0] cell_sum [CN];
    r2dc_pkg::t_cell_ctl      cell_ctl;

    // effective sizes and release threshold
    always_comb begin
        if (r_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_width);
        end
        if (r_height == '0) begin
            eff_h = HW'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_height);
        end
        eff_r = (32'(r_radius) > 32'(RMAX)) ? r2dc_pkg::RAD_W'(RMAX) : r_radius;
        thr   = TW'(eff_r) * TW'(eff_w) + TW'(eff_r);
    end

    assign adv           = !r_o_valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign acc           = s_axis_tvalid && adv;
    assign o_cfg_ready   = 1'b1;

    // decode the request kind
    always_comb begin
        is_pix   = 1'b0;
        is_coef  = 1'b0;
        is_flush = 1'b0;
        unique case (s_axis_tuser)
            r2dc_pkg::OP_PIXEL: is_pix   = acc;
            r2dc_pkg::OP_COEF:  is_coef  = acc;
            r2dc_pkg::OP_FLUSH: is_flush = acc;
            default: ;
        endcase
    end

    // input position, pending count and the result released by this request
    always_comb begin
        cur_col  = (WW'(r_in_col) >= eff_w) ? '0 : r_in_col;
        cur_row  = (HW'(r_in_row) >= eff_h) ? '0 : r_in_row;
        cur_slot = (HW'(r_in_row) >= eff_h) ? '0 : r_in_slot;
        col_inc  = WW'(cur_col) + WW'(1);
        row_inc  = HW'(cur_row) + HW'(1);
        pend_inc = (r_pend == '1) ? r_pend : r_pend + 1'b1;

        out_ok = (HW'(r_out_row) < eff_h) && (WW'(r_out_col) < eff_w);
        orow   = out_ok ? r_out_row : '0;
        ocol   = out_ok ? r_out_col : '0;
        border = (HW'(orow) < HW'(eff_r))
              || ((HW + 1)'(orow) + (HW + 1)'(eff_r) >= (HW + 1)'(eff_h))
              || (WW'(ocol) < WW'(eff_r))
              || ((WW + 1)'(ocol) + (WW + 1)'(eff_r) >= (WW + 1)'(eff_w));
        last   = (HW'(orow) + HW'(1) == eff_h) && (WW'(ocol) + WW'(1) == eff_w);

        emit = (is_pix && (pend_inc > r2dc_pkg::PEND_W'(thr)))
            || (is_flush && (r_pend != '0));

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_in_slot = r_in_slot;
        n_pend    = r_pend;
        if (is_pix) begin
            n_pend = pend_inc;
            if (col_inc >= eff_w) begin
                n_in_col = '0;
                if (row_inc >= eff_h) begin
                    n_in_row  = '0;
                    n_in_slot = '0;
                end else begin
                    n_in_row  = RW'(row_inc);
                    n_in_slot = (cur_slot == SW'(NSLOT - 1)) ? '0 : cur_slot + 1'b1;
                end
            end else begin
                n_in_col  = CW'(col_inc);
                n_in_row  = cur_row;
                n_in_slot = cur_slot;
            end
        end

        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (emit) begin
            n_pend = n_pend - 1'b1;
            if (WW'(ocol) + WW'(1) == eff_w) begin
                n_out_col = '0;
                n_out_row = (HW'(orow) + HW'(1) == eff_h) ? '0 : orow + 1'b1;
            end else begin
                n_out_col = ocol + 1'b1;
                n_out_row = orow;
            end
        end

        a_meta.emit   = emit;
        a_meta.border = border;
        a_meta.last   = last;
        a_meta.row    = PW'(orow);
        a_meta.col    = PW'(ocol);
    end

    // hold configuration, positions, coefficients and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= r2dc_pkg::WIDTH_RST;
            r_height  <= r2dc_pkg::HEIGHT_RST;
            r_radius  <= r2dc_pkg::RADIUS_RST;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_slot <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pend    <= '0;
            for (int k = 0; k < r2dc_pkg::KSLOTS; k++) begin
                r_coef[k] <= '0;
            end
            r_cw_en   <= 1'b0;
            r_b_pix   <= 1'b0;
            r_b_meta  <= '0;
            r_c_meta  <= '0;
            r_d_meta  <= '0;
            r_e_meta  <= '0;
            r_f_meta  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    r2dc_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                    r2dc_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    r2dc_pkg::CFG_RADIUS: r_radius <= i_cfg_data[r2dc_pkg::RAD_W-1:0];
                    default: ;
                endcase
            end
            if (adv && r_cw_en) begin
                r_coef[r_cw_idx] <= r_cw_val;
            end
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_in_slot <= n_in_slot;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_pend    <= n_pend;
            if (adv) begin
                r_cw_en   <= is_coef && (32'(s_axis_tdata[13:8]) < 32'(NCOEF));
                r_b_pix   <= is_pix;
                r_b_meta  <= a_meta;
                r_c_meta  <= r_b_meta;
                r_d_meta  <= r_c_meta;
                r_e_meta  <= r_d_meta;
                r_f_meta  <= r_e_meta;
                r_o_valid <= r_f_meta.emit;
            end
        end
    end

    // advance payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cw_idx   <= s_axis_tdata[13:8];
            r_cw_val   <= $signed(s_axis_tdata[29:14]);
            r_b_sample <= s_axis_tdata[7:0];
            r_b_slot   <= cur_slot;
            r_total    <= n_total;
            if (r_f_meta.emit) begin
                r_o_value <= r_f_meta.border ? '0 : sat_value;
                r_o_row   <= r_f_meta.row;
                r_o_col   <= r_f_meta.col;
                r_o_last  <= r_f_meta.last;
            end
        end
    end

    r2dc_line_store #(
        .DEPTH (MAX_WIDTH),
        .SLOTS (NSLOT)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (is_pix),
        .i_wslot (cur_slot),
        .i_addr  (cur_col),
        .i_wdata (s_axis_tdata[7:0]),
        .i_re    (is_pix),
        .o_rdata (rd)
    );

    // assemble the new column by row age: newest row is the sample itself,
    // rows beyond the kernel are dropped to zero
    always_comb begin
        int s;
        for (int a = 0; a < CN; a++) begin
            s = int'(r_b_slot) - a;
            if (s < 0) begin
                s = s + NSLOT;
            end
            if (a > 2 * int'(eff_r)) begin
                col_vec[a] = '0;
            end else begin
                col_vec[a] = (a == 0) ? r_b_sample : rd[SW'(s)];
            end
        end
    end

    // route coefficients to cells: cell j holds column age j, row index a is row age
    always_comb begin
        int rr;
        int side;
        int k;
        rr   = int'(eff_r);
        side = 2 * rr + 1;
        for (int j = 0; j < CN; j++) begin
            for (int a = 0; a < CN; a++) begin
                k = (2 * rr - a) * side + (2 * rr - j);
                if ((a <= 2 * rr) && (j <= 2 * rr)) begin
                    cell_coef[j][a] = r_coef[r2dc_pkg::IDX_W'(k)];
                end else begin
                    cell_coef[j][a] = '0;
                end
            end
        end
    end

    assign cell_ctl.shift = adv && r_b_pix;
    assign cell_ctl.adv   = adv;

    for (genvar j = 0; j < CN; j++) begin : g_cell
        r2dc_cell #(
            .ROWS   (CN),
            .CSUM_W (CSUM_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl),
            .i_col  ((j == 0) ? col_vec : chain[(j == 0) ? 0 : j - 1]),
            .i_coef (cell_coef[j]),
            .o_col  (chain[j]),
            .o_sum  (cell_sum[j])
        );
    end

    // sum the column sums inside the kernel, then truncate and saturate
    always_comb begin
        logic signed [TOT_W-1:0] q;
        n_total = '0;
        for (int j = 0; j < CN; j++) begin
            if (j <= 2 * int'(eff_r)) begin
                n_total = n_total + TOT_W'(cell_sum[j]);
            end
        end
        q = r_total >>> COEF_FRAC_BITS;
        if (r_total <= 0) begin
            sat_value = '0;
        end else if (q > TOT_W'(255)) begin
            sat_value = 8'hFF;
        end else begin
            sat_value = q[VW-1:0];
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {2'b00, r_o_col, r_o_row, r_o_value};
    assign m_axis_tlast  = r_o_last;

endmodule
